FILE: design/rnfsa_pkg.sv
// ---------------------------------------------------------------------------
// rnfsa_pkg
// shared codes and controller/datapath interface types for the slot allocator
// ---------------------------------------------------------------------------
package rnfsa_pkg;

   // operation codes
   localparam logic [1:0] OP_APPEND    = 2'd0;
   localparam logic [1:0] OP_ERASE_AT  = 2'd1;
   localparam logic [1:0] OP_ERASE_RUN = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_FULL      = 2'd1;
   localparam logic [1:0] ERR_RANGE     = 2'd2;
   localparam logic [1:0] ERR_COUNT     = 2'd3;

   typedef struct packed {
      logic clr_step;
      logic capture;
      logic advance1;
      logic advance2;
      logic set_slot;
      logic clear_slot;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_append;
      logic is_erase_at;
      logic is_erase_run;
      logic err_set;
      logic slot_busy;
      logic cnt_zero;
   } sts_type;

endpackage

FILE: design/rnfsa_ctrl.sv
// ---------------------------------------------------------------------------
// rnfsa_ctrl
// sequencer for clearing pass, slot scan, erase steps and result hand-off
// ---------------------------------------------------------------------------
module rnfsa_ctrl
   import rnfsa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.err_set) begin
               state_in = ST_FINISH;
            end else if (sts.is_append || sts.is_erase_at) begin
               state_in = ST_READ;
            end else if (sts.is_erase_run && !sts.cnt_zero) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_FINISH;
            end
         end
         // memory read of the current slot is in flight
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.is_append) begin
               if (sts.slot_busy) begin
                  cmd.advance1 = 1'b1;
                  state_in     = ST_READ;
               end else begin
                  cmd.set_slot = 1'b1;
                  state_in     = ST_FINISH;
               end
            end else if (sts.is_erase_at) begin
               cmd.clear_slot = sts.slot_busy;
               state_in       = ST_FINISH;
            end else begin
               cmd.clear_slot = sts.slot_busy;
               cmd.advance2   = 1'b1;
               state_in       = ST_DECIDE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: design/rnfsa_dp.sv
// ---------------------------------------------------------------------------
// rnfsa_dp
// slot memories, ring position, occupied count and result registers
// ---------------------------------------------------------------------------
module rnfsa_dp
   import rnfsa_pkg::*;
#(
   parameter int CAPACITY = 1024,
   parameter int SLOTS    = 1280
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_operation,
   input  logic [63:0] req_item_handle,
   input  logic [10:0] req_target_slot,
   input  logic [10:0] req_erase_count,
   output logic [10:0] rsp_slot_index,
   output logic [10:0] rsp_occupied,
   output logic        rsp_at_capacity,
   output logic [1:0]  rsp_error_code
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [IDX_W:0]   SLOTS_X  = (IDX_W + 1)'(SLOTS);

   logic             valid_mem [SLOTS];
   logic [63:0]      handle_mem [SLOTS];

   logic [1:0]       op_ff;
   logic [63:0]      handle_ff;
   logic [10:0]      cnt_ff, cnt_in;
   logic [1:0]       err_ff, err_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] ins_ff, ins_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [IDX_W-1:0] clr_ff;
   logic [IDX_W-1:0] slot_ff;
   logic             rd_ff;

   logic [IDX_W-1:0] pos_next1;
   logic [IDX_W:0]   pos_sum2;
   logic [IDX_W-1:0] pos_next2;
   logic             mem_we;
   logic [IDX_W-1:0] mem_addr;

   logic [10:0]      rsp_slot_ff;
   logic [10:0]      rsp_occ_ff;
   logic             rsp_cap_ff;
   logic [1:0]       rsp_err_ff;

   assign pos_next1 = (pos_ff == LAST_IDX) ? '0 : pos_ff + 1'b1;
   assign pos_sum2  = {1'b0, pos_ff} + (IDX_W + 1)'(2);
   // two single steps with wrap equal one step of two less the ring size
   assign pos_next2 = (pos_sum2 >= SLOTS_X) ? IDX_W'(pos_sum2 - SLOTS_X)
                                            : IDX_W'(pos_sum2);

   always_comb begin
      err_in = ERR_NONE;
      case (req_operation)
         OP_APPEND:    if (32'(occ_ff) >= SLOTS) err_in = ERR_FULL;
         OP_ERASE_AT:  if (32'(req_target_slot) >= SLOTS) err_in = ERR_RANGE;
         OP_ERASE_RUN: if (32'(req_erase_count) > CAPACITY) err_in = ERR_COUNT;
         default:      err_in = ERR_NONE;
      endcase
   end

   always_comb begin
      pos_in = pos_ff;
      ins_in = ins_ff;
      occ_in = occ_ff;
      cnt_in = cnt_ff;
      if (cmd.capture) begin
         pos_in = (req_operation == OP_ERASE_AT) ? IDX_W'(req_target_slot) : ins_ff;
         cnt_in = req_erase_count;
      end
      if (cmd.advance1) pos_in = pos_next1;
      if (cmd.advance2) begin
         pos_in = pos_next2;
         ins_in = pos_next2;
         cnt_in = cnt_ff - 11'd1;
      end
      if (cmd.set_slot) begin
         ins_in = pos_next1;
         occ_in = occ_ff + 1'b1;
      end
      if (cmd.clear_slot) occ_in = occ_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ins_ff <= '0;
         occ_ff <= '0;
         clr_ff <= '0;
      end else begin
         ins_ff <= ins_in;
         occ_ff <= occ_in;
         if (cmd.clr_step) clr_ff <= (clr_ff == LAST_IDX) ? '0 : clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      cnt_ff <= cnt_in;
      if (cmd.capture) begin
         op_ff     <= req_operation;
         handle_ff <= req_item_handle;
         err_ff    <= err_in;
         slot_ff   <= '0;
      end
      if (cmd.set_slot) slot_ff <= pos_ff;
      if (cmd.load_rsp) begin
         rsp_slot_ff <= 11'(slot_ff);
         rsp_occ_ff  <= 11'(occ_ff);
         rsp_cap_ff  <= (32'(occ_ff) == CAPACITY);
         rsp_err_ff  <= err_ff;
      end
   end

   // valid bit memory: one write port, one registered read port
   assign mem_we   = cmd.clr_step || cmd.set_slot || cmd.clear_slot;
   assign mem_addr = cmd.clr_step ? clr_ff : pos_ff;

   always_ff @(posedge clock) begin
      if (mem_we) valid_mem[mem_addr] <= cmd.set_slot;
      rd_ff <= valid_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.set_slot) handle_mem[pos_ff] <= handle_ff;
   end

   always_comb begin
      sts              = '0;
      sts.clr_last     = (clr_ff == LAST_IDX);
      sts.is_append    = (op_ff == OP_APPEND);
      sts.is_erase_at  = (op_ff == OP_ERASE_AT);
      sts.is_erase_run = (op_ff == OP_ERASE_RUN);
      sts.err_set      = (err_ff != ERR_NONE);
      sts.slot_busy    = rd_ff;
      sts.cnt_zero     = (cnt_ff == 11'd0);
   end

   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_occupied    = rsp_occ_ff;
   assign rsp_at_capacity = rsp_cap_ff;
   assign rsp_error_code  = rsp_err_ff;

endmodule

FILE: design/rotating_next_free_slot_allocator_core.sv
// ---------------------------------------------------------------------------
// rotating_next_free_slot_allocator_core
// ring of SLOTS handle slots with next-fit append and erase operations
// ---------------------------------------------------------------------------
// usage:
//  req_ channel carries one operation item: append a handle, erase one slot
//  by index, or erase every other slot over a run starting at the insert
//  position. rsp_ channel returns one item per request with the chosen slot,
//  the occupied count, the at-capacity flag and an error code.
//  after reset the valid-bit memory is swept clear, one slot a cycle, so
//  req_stall stays high over the whole sweep before the first item is taken.
//  an error, an unused code or a zero-count erase-run goes straight to the
//  result register; append probes slot after slot until the first free slot
//  ends the scan; erase-at probes one slot; erase-run probes and steps per count.
//  each probe reads the valid memory through its registered read port.
//  one item is worked on at a time; the next item is taken once the result
//  is in the output register, even while rsp_stall holds it there.
//  a stalled result holds its payload; the block waits before loading the
//  following result until the held one is taken.
// ---------------------------------------------------------------------------
module rotating_next_free_slot_allocator_core
   import rnfsa_pkg::*;
#(
   parameter int CAPACITY = 1024,
   parameter int SLOTS    = 1280
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [63:0] req_item_handle,
   input  logic [10:0] req_target_slot,
   input  logic [10:0] req_erase_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_slot_index,
   output logic [10:0] rsp_occupied,
   output logic        rsp_at_capacity,
   output logic [1:0]  rsp_error_code
);

   cmd_type cmd;
   sts_type sts;

   rnfsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rnfsa_dp #(
      .CAPACITY (CAPACITY),
      .SLOTS    (SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_operation   (req_operation),
      .req_item_handle (req_item_handle),
      .req_target_slot (req_target_slot),
      .req_erase_count (req_erase_count),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_occupied    (rsp_occupied),
      .rsp_at_capacity (rsp_at_capacity),
      .rsp_error_code  (rsp_error_code)
   );

endmodule
